// ----- src/ptst_pkg.sv -----
// Shared types and constants of the peer table block.
package ptst_pkg;

  localparam int PEERS = 16;
  localparam int IDX_W = $clog2(PEERS);
  localparam int CNT_W = $clog2(PEERS + 1);
  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
  localparam int QDEPTH = 2;

  // Reply kinds.
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_REG_ACK = 3'd1;
  localparam logic [2:0] KIND_REG_REJ = 3'd2;
  localparam logic [2:0] KIND_DAT_ACK = 3'd3;
  localparam logic [2:0] KIND_PONG    = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_SPOOF   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;

  // Message types.
  localparam logic [1:0] MT_REG  = 2'd0;
  localparam logic [1:0] MT_DATA = 2'd1;
  localparam logic [1:0] MT_PING = 2'd2;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_IMMED = 3'd0,  // result known in the front, apart from the peer count
    OP_REG   = 3'd1,
    OP_DATA  = 3'd2,
    OP_SWEEP = 3'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  status;
    logic [2:0]  kind;
    logic [47:0] mac;
    logic [63:0] topic;
    logic [7:0]  seq;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  reply_kind;
    logic [47:0] reply_mac;
    logic [7:0]  reply_seq;
    logic [2:0]  status;
    logic [3:0]  peer_index;
    logic [4:0]  peer_count;
    logic [31:0] rx_count;
    logic [31:0] missed_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [63:0] topic;
    logic [31:0] seen;
    logic [7:0]  last_seq;
    logic [31:0] rx;
    logic [31:0] missed;
  } entry_t;

endpackage

// ----- src/ptst_if.sv -----
// Valid/ready channel interfaces for input items and results.
interface ptst_in_if import ptst_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        func;
  logic        frame_short;
  logic [47:0] src_mac;
  logic [47:0] msg_mac;
  logic [1:0]  msg_type;
  logic [63:0] topic_key;
  logic [7:0]  sequence_req;
  logic [31:0] now_ms;
  modport source (output valid, func, frame_short, src_mac, msg_mac, msg_type,
                  topic_key, sequence_req, now_ms, input ready);
  modport sink (input valid, func, frame_short, src_mac, msg_mac, msg_type,
                topic_key, sequence_req, now_ms, output ready);
endinterface

interface ptst_out_if import ptst_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  reply_kind;
  logic [47:0] reply_mac;
  logic [7:0]  reply_seq;
  logic [2:0]  status;
  logic [3:0]  peer_index;
  logic [4:0]  peer_count;
  logic [31:0] rx_count;
  logic [31:0] missed_count;
  logic        last;
  modport source (output valid, reply_kind, reply_mac, reply_seq, status, peer_index,
                  peer_count, rx_count, missed_count, last, input ready);
  modport sink (input valid, reply_kind, reply_mac, reply_seq, status, peer_index,
                peer_count, rx_count, missed_count, last, output ready);
endinterface

// ----- src/ptst_front.sv -----
// Front end: check frames and classify them into table commands.
module ptst_front import ptst_pkg::*; (
  input  logic   rst_n,
  ptst_in_if.sink in_ch,
  output logic   cmd_valid,
  input  logic   cmd_ready,
  output cmd_t   cmd
);

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_IMMED;
    cmd.mac    = in_ch.src_mac;
    cmd.topic  = in_ch.topic_key;
    cmd.seq    = in_ch.sequence_req;
    cmd.now    = in_ch.now_ms;
    cmd.status = ST_OK;
    cmd.kind   = KIND_NONE;
    // classify: sweep first, then short, then spoof, then by type
    if (in_ch.func) begin
      cmd.op = OP_SWEEP;
    end else if (in_ch.frame_short) begin
      cmd.status = ST_SHORT;
    end else if (in_ch.msg_mac != in_ch.src_mac) begin
      cmd.status = ST_SPOOF;
    end else begin
      case (in_ch.msg_type)
        MT_REG:  cmd.op = OP_REG;
        MT_DATA: cmd.op = OP_DATA;
        MT_PING: cmd.kind = KIND_PONG;
        default: cmd.status = ST_UNKNOWN;
      endcase
    end
  end

  assign cmd_valid   = in_ch.valid & rst_n;
  assign in_ch.ready = cmd_ready & rst_n;

endmodule

// ----- src/ptst_queue.sv -----
// Short command queue between front and back.
module ptst_queue import ptst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign wr_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  // write payload
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + 1'b1;
      if (rd_valid && rd_ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(wr_valid && wr_ready) - (PW+1)'(rd_valid && rd_ready);
    end
  end

endmodule

// ----- src/ptst_back.sv -----
// Back end: table storage and sequencer that searches, updates and compacts.
module ptst_back import ptst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  output logic [CNT_W-1:0] total
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DONE  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t           st_r, st_nxt;
  entry_t           tab_r [PEERS];
  logic [CNT_W-1:0] total_r;
  logic [31:0]      timeout_r;
  cmd_t             cur_r;
  logic [CNT_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic             tfound_r, mfound_r;
  logic [IDX_W-1:0] tidx_r, midx_r;
  res_t             res_r;
  logic             rvalid_r;

  logic [IDX_W-1:0] ii;
  entry_t           e;
  logic [31:0]      age;
  logic [7:0]       expect_seq;

  assign ii         = i_r[IDX_W-1:0];
  assign e          = tab_r[ii];
  assign age        = cur_r.now - e.seen;
  assign expect_seq = tab_r[midx_r].last_seq + 8'd1;

  assign total     = total_r;
  assign res       = res_r;
  assign res_valid = rvalid_r;
  assign cmd_ready = (st_r == S_IDLE) && !rvalid_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= TIMEOUT_RESET;
    else if (cfg_we) timeout_r <= cfg_wdata;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (cmd_valid && cmd_ready) st_nxt = (cmd.op == OP_IMMED) ? S_IDLE : S_SCAN;
      S_SCAN: begin
        if (i_r >= total_r) st_nxt = S_DONE;
        else if (cur_r.op == OP_SWEEP && age > timeout_r && !rvalid_r) st_nxt = S_SHIFT;
      end
      S_DONE:  if (!rvalid_r) st_nxt = S_IDLE;
      S_SHIFT: if (j_r == IDX_W'(total_r - 1'b1) || CNT_W'(j_r) + 1'b1 >= total_r)
                 st_nxt = S_OUT;
      S_OUT:   if (!rvalid_r) st_nxt = S_SCAN;
      default: st_nxt = S_IDLE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    res_t rv;
    if (!rst_n) begin
      st_r     <= S_IDLE;
      total_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (rvalid_r && res_ready) rvalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur_r    <= cmd;
            i_r      <= '0;
            tfound_r <= 1'b0;
            mfound_r <= 1'b0;
            if (cmd.op == OP_IMMED) begin
              rv            = '0;
              rv.reply_kind = cmd.kind;
              rv.reply_mac  = cmd.mac;
              rv.status     = cmd.status;
              rv.peer_count = 5'(total_r);
              rv.last       = 1'b1;
              res_r         <= rv;
              rvalid_r      <= 1'b1;
            end
          end
        end
        // walk entries: record matches, or stop on a stale peer
        S_SCAN: begin
          if (i_r < total_r) begin
            if (cur_r.op == OP_SWEEP) begin
              if (age > timeout_r) begin
                // hold the removal until the previous beat has left
                if (!rvalid_r) begin
                  j_r             <= ii;
                  rv              = '0;
                  rv.reply_mac    = e.mac;
                  rv.status       = ST_TIMEOUT;
                  rv.peer_index   = 4'(ii);
                  rv.rx_count     = e.rx;
                  rv.missed_count = e.missed;
                  res_r           <= rv;
                end
              end else begin
                i_r <= i_r + 1'b1;
              end
            end else begin
              if (!tfound_r && e.topic == cur_r.topic && e.mac != cur_r.mac) begin
                tfound_r <= 1'b1;
                tidx_r   <= ii;
              end
              if (!mfound_r && e.mac == cur_r.mac) begin
                mfound_r <= 1'b1;
                midx_r   <= ii;
              end
              i_r <= i_r + 1'b1;
            end
          end
        end
        // close gap one slot per cycle
        S_SHIFT: begin
          if (CNT_W'(j_r) + 1'b1 < total_r) begin
            tab_r[j_r] <= tab_r[j_r + 1'b1];
            j_r        <= j_r + 1'b1;
          end
          if (st_nxt == S_OUT) begin
            total_r          <= total_r - 1'b1;
            res_r.peer_count <= 5'(total_r - 1'b1);
          end
        end
        S_OUT: begin
          if (!rvalid_r) rvalid_r <= 1'b1;
        end
        // finish the command and update the entry
        S_DONE: begin
          if (!rvalid_r) begin
            rvalid_r      <= 1'b1;
            rv            = '0;
            rv.last       = 1'b1;
            rv.peer_count = 5'(total_r);
            if (cur_r.op != OP_SWEEP) rv.reply_mac = cur_r.mac;
            case (cur_r.op)
              OP_REG: begin
                if (tfound_r) begin
                  rv.reply_kind   = KIND_REG_REJ;
                  rv.peer_index   = 4'(tidx_r);
                  rv.rx_count     = tab_r[tidx_r].rx;
                  rv.missed_count = tab_r[tidx_r].missed;
                end else if (mfound_r) begin
                  rv.reply_kind = KIND_REG_ACK;
                  rv.peer_index = 4'(midx_r);
                  tab_r[midx_r].seen     <= cur_r.now;
                  tab_r[midx_r].last_seq <= '0;
                  tab_r[midx_r].rx       <= '0;
                  tab_r[midx_r].missed   <= '0;
                end else if (total_r >= CNT_W'(PEERS)) begin
                  rv.reply_kind = KIND_REG_ACK;
                  rv.status     = ST_FULL;
                end else begin
                  rv.reply_kind = KIND_REG_ACK;
                  rv.peer_index = 4'(total_r);
                  rv.peer_count = 5'(total_r + 1'b1);
                  tab_r[total_r[IDX_W-1:0]] <= '{mac: cur_r.mac, topic: cur_r.topic,
                    seen: cur_r.now, last_seq: 8'd0, rx: 32'd0, missed: 32'd0};
                  total_r <= total_r + 1'b1;
                end
              end
              OP_DATA: begin
                if (!mfound_r) begin
                  rv.reply_kind = KIND_REG_REJ;
                end else begin
                  rv.reply_kind = KIND_DAT_ACK;
                  rv.reply_seq  = cur_r.seq;
                  rv.peer_index = 4'(midx_r);
                  rv.rx_count   = tab_r[midx_r].rx + 32'd1;
                  tab_r[midx_r].rx       <= tab_r[midx_r].rx + 32'd1;
                  tab_r[midx_r].seen     <= cur_r.now;
                  tab_r[midx_r].last_seq <= cur_r.seq;
                  if (cur_r.seq != expect_seq && tab_r[midx_r].last_seq != 8'd0) begin
                    tab_r[midx_r].missed <= tab_r[midx_r].missed
                                            + 32'(8'(cur_r.seq - expect_seq));
                    rv.missed_count      = tab_r[midx_r].missed
                                            + 32'(8'(cur_r.seq - expect_seq));
                  end else begin
                    rv.missed_count = tab_r[midx_r].missed;
                  end
                end
              end
              default: ;
            endcase
            res_r <= rv;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- src/peer_table_with_sequence_tracking.sv -----
// Top level of the peer table with sequence tracking.
// Short, spoofed, ping and unknown-type frames give their result in the cycle after
// the queue hands them over; registration and data scan the filled slots, then finish.
// A sweep scans the filled slots and shifts the table over each removed peer, then
// finishes. One item at a time in the back end; stalls hold it.
// Reset (rst_n low, synchronous) empties the table and loads timeout 30000 ms.
module peer_table_with_sequence_tracking import ptst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ptst_in_if.sink     in_ch,
  ptst_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic             f_valid, f_ready, q_valid, q_ready;
  cmd_t             f_cmd, q_cmd;
  res_t             res;
  logic [CNT_W-1:0] total;

  ptst_front u_front (.rst_n, .in_ch, .cmd_valid(f_valid), .cmd_ready(f_ready),
                      .cmd(f_cmd));

  ptst_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready),
                      .wr_data(f_cmd), .rd_valid(q_valid), .rd_ready(q_ready),
                      .rd_data(q_cmd));

  ptst_back u_back (.clk, .rst_n, .cfg_we, .cfg_wdata, .cmd_valid(q_valid),
                    .cmd_ready(q_ready), .cmd(q_cmd), .res_valid(out_ch.valid),
                    .res_ready(out_ch.ready), .res, .total);

  assign out_ch.reply_kind   = res.reply_kind;
  assign out_ch.reply_mac    = res.reply_mac;
  assign out_ch.reply_seq    = res.reply_seq;
  assign out_ch.status       = res.status;
  assign out_ch.peer_index   = res.peer_index;
  assign out_ch.peer_count   = res.peer_count;
  assign out_ch.rx_count     = res.rx_count;
  assign out_ch.missed_count = res.missed_count;
  assign out_ch.last         = res.last;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CNT_W'(PEERS)) else $error("table count above capacity");
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.peer_count <= 5'(PEERS)) else $error("bad peer count");
  a_timeout_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_TIMEOUT) |-> !out_ch.last)
    else $error("removal marked last");
`endif

endmodule
